FILE: src/wsx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wsx_pkg;

  localparam int WS_BITS      = 24;
  localparam int STRINGS_DEF  = 24;
  localparam int PIN_W        = 6;
  localparam int MAP_W        = 48;
  localparam int CFG_IDX_W    = 3;
  localparam int LINE_W       = 10;
  localparam int IDX_W        = 5;

  localparam logic [IDX_W-1:0]  STRING_COUNT_RST  = 5'd24;
  localparam logic [LINE_W-1:0] BITS_PER_LINE_RST = 10'd120;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ROW_END = 2'd1,
    OP_FRAME   = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PIN_MAP_A     = 3'd0,
    REG_PIN_MAP_B     = 3'd1,
    REG_PIN_MAP_C     = 3'd2,
    REG_STRING_COUNT  = 3'd3,
    REG_BITS_PER_LINE = 3'd4
  } cfg_reg_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic frame_clear;
    logic emit_begin;
    logic emit_step;
  } dp_cmd_t;

  typedef struct packed {
    logic bit_last;
  } dp_status_t;

endpackage
`default_nettype wire

FILE: src/wsx_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module wsx_ctrl
  import wsx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire logic [1:0] op,
  input  wire dp_status_t status,
  output dp_cmd_t         cmd,
  output logic            busy
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign accept = start && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (op == OP_ROW_END)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.bit_last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_LOAD:    cmd.load        = 1'b1;
            OP_ROW_END: cmd.emit_begin  = 1'b1;
            OP_FRAME:   cmd.frame_clear = 1'b1;
            default:    cmd             = '0;
          endcase
        end
      end
      ST_EMIT: begin
        busy          = 1'b1;
        cmd.emit_step = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/wsx_dp.sv
`timescale 1ns / 1ps
`default_nettype none
module wsx_dp
  import wsx_pkg::*;
#(
  parameter int STRINGS = STRINGS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire dp_cmd_t              cmd,
  output dp_status_t                status,
  input  wire logic [IDX_W-1:0]     string_index,
  input  wire logic [WS_BITS-1:0]   pixel_value,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_data,
  output logic                      result_strobe,
  output logic [WS_BITS-1:0]        slot_word,
  output logic [IDX_W-1:0]          bit_index,
  output logic                      line_end,
  output logic                      last
);

  localparam logic [IDX_W-1:0] STR_MAX  = IDX_W'(STRINGS);
  localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(WS_BITS - 1);
  localparam logic [PIN_W-1:0] PIN_MAX  = PIN_W'(WS_BITS - 1);

  logic [MAP_W-1:0]   pin_map_a;
  logic [MAP_W-1:0]   pin_map_b;
  logic [MAP_W-1:0]   pin_map_c;
  logic [IDX_W-1:0]   string_count;
  logic [LINE_W-1:0]  bits_per_line;

  logic [WS_BITS-1:0] row_store [STRINGS];
  logic [STRINGS-1:0] row_valid;
  logic [IDX_W-1:0]   bit_cnt;
  logic [LINE_W-1:0]  slots_on_line;

  logic [3*MAP_W-1:0] pin_all;
  logic [IDX_W-1:0]   active;
  logic [WS_BITS-1:0] word_next;
  logic [PIN_W-1:0]   pin;
  logic [LINE_W-1:0]  slots_inc;
  logic               lend_next;

  assign pin_all         = {pin_map_c, pin_map_b, pin_map_a};
  assign active          = (string_count > STR_MAX) ? STR_MAX : string_count;
  assign status.bit_last = (bit_cnt == BIT_LAST);
  assign slots_inc       = slots_on_line + LINE_W'(1);
  assign lend_next       = (slots_inc == bits_per_line);

  always_ff @(posedge clk) begin
    if (rst) begin
      pin_map_a     <= '1;
      pin_map_b     <= '1;
      pin_map_c     <= '1;
      string_count  <= STRING_COUNT_RST;
      bits_per_line <= BITS_PER_LINE_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_PIN_MAP_A:     pin_map_a     <= cfg_data;
        REG_PIN_MAP_B:     pin_map_b     <= cfg_data;
        REG_PIN_MAP_C:     pin_map_c     <= cfg_data;
        REG_STRING_COUNT:  string_count  <= cfg_data[IDX_W-1:0];
        REG_BITS_PER_LINE: bits_per_line <= cfg_data[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // One OR-combined decode per string; an entry that is not valid reads as zero.
  always_comb begin
    pin       = '0;
    word_next = '0;
    for (int s = 0; s < STRINGS; s++) begin
      pin = pin_all[PIN_W*s +: PIN_W];
      if ((IDX_W'(s) < active) && row_valid[s] && (pin <= PIN_MAX) &&
          row_store[s][BIT_LAST - bit_cnt]) begin
        word_next[BIT_LAST - pin[IDX_W-1:0]] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STRINGS; s++) begin
      if (cmd.load && (string_index == IDX_W'(s))) begin
        row_store[s] <= pixel_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid     <= '0;
      bit_cnt       <= '0;
      slots_on_line <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= cmd.emit_step;
      for (int s = 0; s < STRINGS; s++) begin
        if (cmd.load && (string_index == IDX_W'(s))) begin
          row_valid[s] <= 1'b1;
        end
      end
      if (cmd.frame_clear) begin
        slots_on_line <= '0;
      end
      if (cmd.emit_begin) begin
        bit_cnt <= '0;
      end
      if (cmd.emit_step) begin
        bit_cnt       <= bit_cnt + IDX_W'(1);
        slots_on_line <= lend_next ? '0 : slots_inc;
        // drop the row once its final slot is out
        if (status.bit_last) begin
          row_valid <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      slot_word <= word_next;
      bit_index <= bit_cnt;
      line_end  <= lend_next;
      last      <= status.bit_last;
    end
  end

endmodule
`default_nettype wire

FILE: src/ws281x_parallel_bit_transposer.sv
// Channel   Handshake                       Payload
// request   start, busy (taken: start&!busy) op, string_index, pixel_value
// config    cfg_write                       cfg_index, cfg_data
// result    result_strobe (per word)        slot_word, bit_index, line_end, last
//
// A load or frame-start request is taken while idle and leaves busy low.
// A row-end request holds busy high after it is taken, until its last slot: one slot
// word per cycle from the shared transpose/OR stage, stepped by the datapath's bit
// counter. Each word shows on the result ports in the cycle after its step, and
// the next request can be taken once busy falls again.
// rst is synchronous; the row store reads as zero after reset with no sweep.
// The receiver cannot stall: every strobe cycle delivers one result.
`timescale 1ns / 1ps
`default_nettype none
module ws281x_parallel_bit_transposer
  import wsx_pkg::*;
#(
  parameter int STRINGS = STRINGS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [1:0]           op,
  input  wire logic [IDX_W-1:0]     string_index,
  input  wire logic [WS_BITS-1:0]   pixel_value,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [MAP_W-1:0]     cfg_data,
  output logic                      result_strobe,
  output logic [WS_BITS-1:0]        slot_word,
  output logic [IDX_W-1:0]          bit_index,
  output logic                      line_end,
  output logic                      last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  wsx_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  wsx_dp #(
    .STRINGS (STRINGS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .string_index  (string_index),
    .pixel_value   (pixel_value),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .result_strobe (result_strobe),
    .slot_word     (slot_word),
    .bit_index     (bit_index),
    .line_end      (line_end),
    .last          (last)
  );

endmodule
`default_nettype wire
